[hdl/ivs_pkg.sv]
package ivs_pkg;

    localparam int REQ_W      = 32;
    localparam int DIM_W      = 16;
    localparam int PROD_W     = REQ_W + DIM_W;
    localparam int DIFF_W     = REQ_W + 1;
    localparam int OUT_IDX_W  = 4;
    localparam int OUT_CNT_W  = 5;
    localparam int ENTRY_W    = 2 * DIM_W;

    typedef enum logic [1:0] {
        OP_CLEAR  = 2'd0,
        OP_APPEND = 2'd1,
        OP_QUERY  = 2'd2,
        OP_NONE   = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_EMPTY    = 2'd1,
        ST_ZERO_REQ = 2'd2,
        ST_FULL     = 2'd3
    } t_status;

    // Operands of one cross multiplication: a*b is compared against c*d.
    typedef struct packed {
        logic [REQ_W-1:0] a;
        logic [DIM_W-1:0] b;
        logic [REQ_W-1:0] c;
        logic [DIM_W-1:0] d;
    } t_xmul_req;

    typedef struct packed {
        logic lt;
        logic eq;
    } t_cmp;

endpackage

[hdl/ivs_ram.sv]
module ivs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[hdl/ivs_xmul.sv]
module ivs_xmul (
    input  logic               i_clk,
    input  ivs_pkg::t_xmul_req i_req,
    output ivs_pkg::t_cmp      o_cmp
);

    import ivs_pkg::*;

    logic [PROD_W-1:0] r_p1;
    logic [PROD_W-1:0] r_p2;

    // Both products are registered; o_cmp compares the operands presented in the
    // previous cycle.
    always_ff @(posedge i_clk) begin
        r_p1 <= PROD_W'(i_req.a) * PROD_W'(i_req.b);
        r_p2 <= PROD_W'(i_req.c) * PROD_W'(i_req.d);
    end

    assign o_cmp.lt = (r_p1 < r_p2);
    assign o_cmp.eq = (r_p1 == r_p2);

endmodule

[hdl/image_variant_selector.sv]
// Image variant selector.
// Input channel (i_in_valid / o_in_ready) takes one item: an operation code with
// an entry size for an append and a requested size for a query. Output channel
// (o_out_valid / i_out_ready) returns exactly one item per input item: status,
// chosen index and the number of entries held after the item.
// Clear, append, unused codes and rejected queries load the output register one
// cycle after the accept, and the next item can be taken one cycle after that.
// A query loads it once every stored entry has been scanned and the register is
// free: each entry needs a table read, a size compare, and up to three passes
// through the single shared cross multiplier (scale select, best fit against the
// current fit candidate, smallest scale against the current fallback candidate).
// An entry that would need upscaling skips the best fit pass, and one with a zero
// dimension goes no further than its table read.
// The block works on one item at a time; o_in_ready is high only when idle.
// The result sits in an output register, so the block goes idle as soon as the
// register is loaded; if the receiver stalls with a result still held, the next
// item finishes its work and then waits until the register is free.
// After reset the table is empty and no result is pending. Table contents are
// not cleared; only entries below the count are ever read.
module image_variant_selector #(
    parameter int MAX_VARIANTS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [1:0]  i_operation,
    input  logic [15:0] i_entry_width,
    input  logic [15:0] i_entry_height,
    input  logic [31:0] i_request_width,
    input  logic [31:0] i_request_height,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [1:0]  o_status,
    output logic [3:0]  o_chosen_index,
    output logic [4:0]  o_entry_count
);

    import ivs_pkg::*;

    localparam int CNT_W = $clog2(MAX_VARIANTS + 1);
    localparam int IDX_W = (MAX_VARIANTS > 1) ? $clog2(MAX_VARIANTS) : 1;

    typedef enum logic [8:0] {
        S_IDLE  = 9'b000000001,
        S_READ  = 9'b000000010,
        S_SEL   = 9'b000000100,
        S_SCALE = 9'b000001000,
        S_FIT   = 9'b000010000,
        S_FITC  = 9'b000100000,
        S_ANY   = 9'b001000000,
        S_ANYC  = 9'b010000000,
        S_FIN   = 9'b100000000
    } t_state;

    t_state r_state, n_state;

    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] r_idx;
    t_status          r_status;
    logic [REQ_W-1:0] r_req_w;
    logic [REQ_W-1:0] r_req_h;

    logic [REQ_W-1:0]  r_sn;
    logic [DIM_W-1:0]  r_sd;
    logic [DIFF_W-1:0] r_diff;

    logic              r_fit_found;
    logic [REQ_W-1:0]  r_fn;
    logic [DIM_W-1:0]  r_fd;
    logic [DIFF_W-1:0] r_fdiff;
    logic [IDX_W-1:0]  r_fidx;

    logic              r_any_found;
    logic [REQ_W-1:0]  r_un;
    logic [DIM_W-1:0]  r_ud;
    logic [DIFF_W-1:0] r_udiff;
    logic [IDX_W-1:0]  r_uidx;

    logic             r_out_valid;
    t_status          r_out_status;
    logic [IDX_W-1:0] r_out_chosen;
    logic [CNT_W-1:0] r_out_count;

    logic             w_accept;
    logic             w_full;
    logic             w_ram_we;
    logic [ENTRY_W-1:0] w_rdata;
    logic [DIM_W-1:0] w_w;
    logic [DIM_W-1:0] w_h;
    logic             w_zero_dim;
    logic [CNT_W-1:0] w_idx_inc;
    logic             w_last;
    logic             w_advance;
    logic             w_out_free;
    logic [REQ_W-1:0] w_ext_w;
    logic [REQ_W-1:0] w_ext_h;
    logic [REQ_W-1:0] w_adw;
    logic [REQ_W-1:0] w_adh;
    logic [DIFF_W-1:0] w_diff;
    logic [REQ_W-1:0] w_sn;
    logic [DIM_W-1:0] w_sd;
    logic             w_fit_ok;
    logic             w_fit_upd;
    logic             w_any_upd;
    t_xmul_req        w_xreq;
    t_cmp             w_cmp;

    assign o_in_ready = (r_state == S_IDLE);
    assign w_accept   = i_in_valid && o_in_ready;
    assign w_full     = (r_count == CNT_W'(MAX_VARIANTS));
    assign w_ram_we   = w_accept && (t_op'(i_operation) == OP_APPEND) && !w_full;
    assign w_out_free = !r_out_valid || i_out_ready;

    ivs_ram #(
        .WIDTH(ENTRY_W),
        .DEPTH(MAX_VARIANTS)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_waddr (r_count[IDX_W-1:0]),
        .i_wdata ({i_entry_width, i_entry_height}),
        .i_raddr (r_idx[IDX_W-1:0]),
        .o_rdata (w_rdata)
    );

    assign w_w        = w_rdata[ENTRY_W-1:DIM_W];
    assign w_h        = w_rdata[DIM_W-1:0];
    assign w_zero_dim = (w_w == '0) || (w_h == '0);
    assign w_idx_inc  = r_idx + CNT_W'(1);
    assign w_last     = (w_idx_inc == r_count);
    assign w_advance  = ((r_state == S_SEL) && w_zero_dim) || (r_state == S_ANYC);

    assign w_ext_w = REQ_W'(w_w);
    assign w_ext_h = REQ_W'(w_h);
    assign w_adw   = (w_ext_w > r_req_w) ? (w_ext_w - r_req_w) : (r_req_w - w_ext_w);
    assign w_adh   = (w_ext_h > r_req_h) ? (w_ext_h - r_req_h) : (r_req_h - w_ext_h);
    assign w_diff  = DIFF_W'(w_adw) + DIFF_W'(w_adh);

    // The scale is the larger of the two ratios; the products of the
    // select pass say whether the width ratio is at least the height ratio.
    assign w_sn     = w_cmp.lt ? r_req_h : r_req_w;
    assign w_sd     = w_cmp.lt ? w_h : w_w;
    assign w_fit_ok = (w_sn <= REQ_W'(w_sd));

    assign w_fit_upd = !r_fit_found || (!w_cmp.lt && !w_cmp.eq)
                       || (w_cmp.eq && (r_diff < r_fdiff));
    assign w_any_upd = !r_any_found || w_cmp.lt
                       || (w_cmp.eq && (r_diff < r_udiff));

    always_comb begin
        w_xreq.a = r_req_w;
        w_xreq.b = w_h;
        w_xreq.c = r_req_h;
        w_xreq.d = w_w;
        unique case (r_state)
            S_FIT: begin
                w_xreq.a = r_sn;
                w_xreq.b = r_fd;
                w_xreq.c = r_fn;
                w_xreq.d = r_sd;
            end
            S_FITC, S_ANY: begin
                w_xreq.a = r_sn;
                w_xreq.b = r_ud;
                w_xreq.c = r_un;
                w_xreq.d = r_sd;
            end
            default: begin
            end
        endcase
    end

    ivs_xmul u_xmul (
        .i_clk (i_clk),
        .i_req (w_xreq),
        .o_cmp (w_cmp)
    );

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    if ((t_op'(i_operation) == OP_QUERY) && (r_count != '0)
                        && (i_request_width != '0) && (i_request_height != '0)) begin
                        n_state = S_READ;
                    end else begin
                        n_state = S_FIN;
                    end
                end
            end
            S_READ:  n_state = S_SEL;
            S_SEL:   n_state = w_zero_dim ? (w_last ? S_FIN : S_READ) : S_SCALE;
            S_SCALE: n_state = w_fit_ok ? S_FIT : S_ANY;
            S_FIT:   n_state = S_FITC;
            S_FITC:  n_state = S_ANYC;
            S_ANY:   n_state = S_ANYC;
            S_ANYC:  n_state = w_last ? S_FIN : S_READ;
            S_FIN:   n_state = w_out_free ? S_IDLE : S_FIN;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_idx       <= '0;
            r_fit_found <= 1'b0;
            r_any_found <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_accept) begin
                r_idx       <= '0;
                r_fit_found <= 1'b0;
                r_any_found <= 1'b0;
                unique case (t_op'(i_operation))
                    OP_CLEAR:  r_count <= '0;
                    OP_APPEND: begin
                        if (!w_full) begin
                            r_count <= r_count + CNT_W'(1);
                        end
                    end
                    default: begin
                    end
                endcase
            end
            if (w_advance && !w_last) begin
                r_idx <= w_idx_inc;
            end
            if ((r_state == S_FITC) && w_fit_upd) begin
                r_fit_found <= 1'b1;
            end
            if ((r_state == S_ANYC) && w_any_upd) begin
                r_any_found <= 1'b1;
            end
            if ((r_state == S_FIN) && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_req_w <= i_request_width;
            r_req_h <= i_request_height;
            r_fidx  <= '0;
            r_uidx  <= '0;
            unique case (t_op'(i_operation))
                OP_APPEND: r_status <= w_full ? ST_FULL : ST_OK;
                OP_QUERY: begin
                    if (r_count == '0) begin
                        r_status <= ST_EMPTY;
                    end else if ((i_request_width == '0) || (i_request_height == '0)) begin
                        r_status <= ST_ZERO_REQ;
                    end else begin
                        r_status <= ST_OK;
                    end
                end
                default: r_status <= ST_OK;
            endcase
        end
        if (r_state == S_SEL) begin
            r_diff <= w_diff;
        end
        if (r_state == S_SCALE) begin
            r_sn <= w_sn;
            r_sd <= w_sd;
        end
        if ((r_state == S_FITC) && w_fit_upd) begin
            r_fn    <= r_sn;
            r_fd    <= r_sd;
            r_fdiff <= r_diff;
            r_fidx  <= r_idx[IDX_W-1:0];
        end
        if ((r_state == S_ANYC) && w_any_upd) begin
            r_un    <= r_sn;
            r_ud    <= r_sd;
            r_udiff <= r_diff;
            r_uidx  <= r_idx[IDX_W-1:0];
        end
        if ((r_state == S_FIN) && w_out_free) begin
            r_out_status <= r_status;
            r_out_chosen <= r_fit_found ? r_fidx : r_uidx;
            r_out_count  <= r_count;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_status       = r_out_status;
    assign o_chosen_index = OUT_IDX_W'(r_out_chosen);
    assign o_entry_count  = OUT_CNT_W'(r_out_count);

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(MAX_VARIANTS))
        else $error("entry count exceeds table depth");

    a_scan_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_READ || r_state == S_SEL || r_state == S_SCALE
         || r_state == S_FIT || r_state == S_FITC || r_state == S_ANY
         || r_state == S_ANYC) |-> (r_idx < r_count))
        else $error("scan index beyond stored entries");

    a_fit_no_upscale: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fit_found |-> (r_fn <= REQ_W'(r_fd)))
        else $error("fit candidate needs upscaling");

    a_index_only_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_chosen_index != '0)) |-> (o_status == ST_OK))
        else $error("nonzero index with error status");

    a_fin_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_FIN) && !r_out_valid) |=> o_out_valid)
        else $error("finished item not presented");

endmodule

[tb/variant_fit_checker.sv]
`timescale 1ns / 1ps

module variant_fit_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic        i_in_ready,
    input  logic [1:0]  i_operation,
    input  logic [15:0] i_entry_width,
    input  logic [15:0] i_entry_height,
    input  logic [31:0] i_request_width,
    input  logic [31:0] i_request_height,
    input  logic        i_out_valid,
    input  logic        i_out_ready,
    input  logic [1:0]  i_status,
    input  logic [3:0]  i_chosen_index,
    input  logic [4:0]  i_entry_count,
    output int          o_mismatches,
    output int          o_awaiting
);

    import ivs_pkg::*;

    localparam int TABLE_DEPTH = 16;

    typedef struct packed {
        t_status    status;
        logic [3:0] index;
        logic [4:0] count;
    } t_fit_answer;

    logic [15:0] widths_mem [TABLE_DEPTH];
    logic [15:0] heights_mem [TABLE_DEPTH];
    logic [4:0]  held_count = '0;
    t_fit_answer fit_answers [$];
    int          mismatch_total = 0;

    assign o_mismatches = mismatch_total;

    function automatic int compare_scales(logic [63:0] n1, logic [63:0] d1,
                                          logic [63:0] n2, logic [63:0] d2);
        logic [63:0] lhs;
        logic [63:0] rhs;
        lhs = n1 * d2;
        rhs = n2 * d1;
        if (lhs < rhs) return -1;
        if (lhs > rhs) return 1;
        return 0;
    endfunction

    function automatic t_fit_answer apply_item(t_op op, logic [15:0] ew, logic [15:0] eh,
                                               logic [31:0] rw, logic [31:0] rh);
        t_fit_answer ans;
        logic [63:0] req_w, req_h, w, h, sn, sd, diff;
        logic [63:0] fit_n, fit_d, fit_diff, any_n, any_d, any_diff;
        bit          fit_found, any_found;
        int          fit_idx, any_idx, c;
        ans.status = ST_OK;
        ans.index  = '0;
        case (op)
            OP_CLEAR: begin
                held_count = '0;
            end
            OP_APPEND: begin
                if (held_count >= TABLE_DEPTH) begin
                    ans.status = ST_FULL;
                end else begin
                    widths_mem[held_count]  = ew;
                    heights_mem[held_count] = eh;
                    held_count = held_count + 5'd1;
                end
            end
            OP_QUERY: begin
                if (held_count == 0) begin
                    ans.status = ST_EMPTY;
                end else if (rw == 0 || rh == 0) begin
                    ans.status = ST_ZERO_REQ;
                end else begin
                    req_w = 64'(rw);
                    req_h = 64'(rh);
                    fit_found = 0;
                    any_found = 0;
                    fit_n = 0; fit_d = 1; fit_diff = 0;
                    any_n = 0; any_d = 1; any_diff = 0;
                    fit_idx = 0;
                    any_idx = 0;
                    for (int i = 0; i < int'(held_count); i++) begin
                        w = 64'(widths_mem[i]);
                        h = 64'(heights_mem[i]);
                        if (w == 0 || h == 0) continue;
                        if (req_w * h >= req_h * w) begin
                            sn = req_w;
                            sd = w;
                        end else begin
                            sn = req_h;
                            sd = h;
                        end
                        diff = (w > req_w ? w - req_w : req_w - w)
                             + (h > req_h ? h - req_h : req_h - h);
                        if (sn <= sd) begin
                            c = fit_found ? compare_scales(sn, sd, fit_n, fit_d) : 1;
                            if (c > 0 || (c == 0 && diff < fit_diff)) begin
                                fit_found = 1;
                                fit_n = sn; fit_d = sd; fit_diff = diff; fit_idx = i;
                            end
                        end
                        c = any_found ? compare_scales(sn, sd, any_n, any_d) : -1;
                        if (c < 0 || (c == 0 && diff < any_diff)) begin
                            any_found = 1;
                            any_n = sn; any_d = sd; any_diff = diff; any_idx = i;
                        end
                    end
                    ans.index = 4'(fit_found ? fit_idx : (any_found ? any_idx : 0));
                end
            end
            default: begin
            end
        endcase
        ans.count = held_count;
        return ans;
    endfunction

    task automatic flag(string what, int want, int got);
        $display("%0t: %s expected %0d, actual %0d", $time, what, want, got);
        mismatch_total++;
    endtask

    always @(posedge i_clk) begin
        t_fit_answer want;
        if (!i_rst_n) begin
            held_count = '0;
            fit_answers.delete();
        end else begin
            if (i_out_valid && i_out_ready) begin
                if (fit_answers.size() == 0) begin
                    flag("unexpected item, pending count", 0, 1);
                end else begin
                    want = fit_answers.pop_front();
                    if (i_status !== want.status) begin
                        flag("status", int'(want.status), int'(i_status));
                    end
                    if (i_chosen_index !== want.index) begin
                        flag("chosen index", int'(want.index), int'(i_chosen_index));
                    end
                    if (i_entry_count !== want.count) begin
                        flag("entry count", int'(want.count), int'(i_entry_count));
                    end
                end
            end
            if (i_in_valid && i_in_ready) begin
                fit_answers.insert(fit_answers.size(),
                                   apply_item(t_op'(i_operation), i_entry_width,
                                              i_entry_height, i_request_width,
                                              i_request_height));
            end
        end
        o_awaiting <= fit_answers.size();
    end

endmodule

[tb/tb_image_variant_selector.sv]
`timescale 1ns / 1ps

module tb_image_variant_selector;
    import ivs_pkg::*;

    localparam int TOTAL_ITEMS  = 1950;
    localparam int CALM_FROM    = TOTAL_ITEMS - 150;
    localparam int LIMIT_CYCLES = 1500000;
    localparam int TAIL_CYCLES  = 120;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic [1:0]  i_operation = OP_CLEAR;
    logic [15:0] i_entry_width = '0;
    logic [15:0] i_entry_height = '0;
    logic [31:0] i_request_width = '0;
    logic [31:0] i_request_height = '0;
    logic        i_out_ready = 1'b0;
    logic        o_in_ready;
    logic        o_out_valid;
    logic [1:0]  o_status;
    logic [3:0]  o_chosen_index;
    logic [4:0]  o_entry_count;

    int mismatches;
    int awaiting;
    int cycles = 0;
    int sent = 0;
    int gap_odds = 0;
    int stall_odds = 0;
    int stall_left = 0;
    bit calm = 0;

    image_variant_selector u_top (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_ready       (o_in_ready),
        .i_operation      (i_operation),
        .i_entry_width    (i_entry_width),
        .i_entry_height   (i_entry_height),
        .i_request_width  (i_request_width),
        .i_request_height (i_request_height),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_status         (o_status),
        .o_chosen_index   (o_chosen_index),
        .o_entry_count    (o_entry_count)
    );

    variant_fit_checker u_fit_checker (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .i_in_ready       (o_in_ready),
        .i_operation      (i_operation),
        .i_entry_width    (i_entry_width),
        .i_entry_height   (i_entry_height),
        .i_request_width  (i_request_width),
        .i_request_height (i_request_height),
        .i_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .i_status         (o_status),
        .i_chosen_index   (o_chosen_index),
        .i_entry_count    (o_entry_count),
        .o_mismatches     (mismatches),
        .o_awaiting       (awaiting)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= LIMIT_CYCLES) begin
            $display("FAIL");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (calm || stall_odds == 0) begin
            i_out_ready <= 1'b1;
        end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            i_out_ready <= 1'b0;
        end else if ($urandom_range(1, stall_odds) == 1) begin
            stall_left <= $urandom_range(0, 17);
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= 1'b1;
        end
    end

    task automatic put_item(t_op op, logic [15:0] ew, logic [15:0] eh,
                            logic [31:0] rw, logic [31:0] rh);
        if (!calm && gap_odds != 0 && $urandom_range(1, gap_odds) == 1) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge i_clk);
        end
        i_in_valid       <= 1'b1;
        i_operation      <= op;
        i_entry_width    <= ew;
        i_entry_height   <= eh;
        i_request_width  <= rw;
        i_request_height <= rh;
        do @(posedge i_clk); while (!o_in_ready);
        sent++;
        calm = (sent >= CALM_FROM);
    endtask

    task automatic drain_results();
        i_in_valid <= 1'b0;
        @(negedge i_clk);
        while (awaiting != 0) @(negedge i_clk);
        @(posedge i_clk);
    endtask

    function automatic logic [15:0] pick_dim();
        case ($urandom_range(0, 11))
            0:       return 16'd0;
            1:       return 16'hFFFF;
            2, 3:    return 16'($urandom);
            default: return 16'($urandom_range(1, 48));
        endcase
    endfunction

    function automatic logic [31:0] pick_extent(logic [15:0] near);
        case ($urandom_range(0, 15))
            0:       return 32'd0;
            1:       return 32'hFFFF_FFFF;
            2, 3:    return 32'($urandom);
            4, 5:    return 32'(near);
            6:       return 32'(near) + 32'($urandom_range(0, 3));
            default: return 32'($urandom_range(1, 96));
        endcase
    endfunction

    initial begin
        logic [15:0] w;
        logic [15:0] h;
        int          seq_no;
        w = 16'd16;
        h = 16'd16;
        seq_no = 0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        put_item(OP_QUERY, 16'd0, 16'd0, 32'd10, 32'd10);
        put_item(OP_QUERY, 16'd0, 16'd0, 32'd0, 32'd0);
        put_item(OP_NONE, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        put_item(OP_APPEND, 16'd0, 16'd40, 32'd0, 32'd0);
        put_item(OP_APPEND, 16'd40, 16'd0, 32'd0, 32'd0);
        put_item(OP_QUERY, 16'd0, 16'd0, 32'd20, 32'd20);
        put_item(OP_QUERY, 16'd0, 16'd0, 32'd0, 32'd20);
        put_item(OP_QUERY, 16'd0, 16'd0, 32'd20, 32'd0);
        put_item(OP_APPEND, 16'hFFFF, 16'hFFFF, 32'd0, 32'd0);
        put_item(OP_APPEND, 16'd1, 16'd1, 32'd0, 32'd0);
        put_item(OP_APPEND, 16'd64, 16'd32, 32'd0, 32'd0);
        put_item(OP_APPEND, 16'd64, 16'd32, 32'd0, 32'd0);
        put_item(OP_APPEND, 16'd32, 16'd64, 32'd0, 32'd0);
        put_item(OP_QUERY, 16'd0, 16'd0, 32'd64, 32'd32);
        put_item(OP_QUERY, 16'd0, 16'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        put_item(OP_QUERY, 16'd0, 16'd0, 32'd1, 32'd1);
        put_item(OP_QUERY, 16'd0, 16'd0, 32'd48, 32'd48);
        put_item(OP_QUERY, 16'd0, 16'd0, 32'h0001_0000, 32'd1);
        put_item(OP_QUERY, 16'd0, 16'd0, 32'd100, 32'd30);
        put_item(OP_NONE, 16'd0, 16'd0, 32'd0, 32'd0);
        put_item(OP_CLEAR, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        put_item(OP_QUERY, 16'd0, 16'd0, 32'd5, 32'd5);
        drain_results();
        sent = 0;

        while (sent < TOTAL_ITEMS) begin
            case ($urandom_range(0, 2))
                0:       gap_odds = 0;
                1:       gap_odds = 3;
                default: gap_odds = 8;
            endcase
            case ($urandom_range(0, 2))
                0:       stall_odds = 0;
                1:       stall_odds = 4;
                default: stall_odds = 12;
            endcase
            if ($urandom_range(0, 6) == 0) begin
                repeat ($urandom_range(1, 4)) begin
                    put_item(t_op'($urandom_range(0, 3)), 16'($urandom), 16'($urandom),
                             32'($urandom), 32'($urandom));
                end
            end else begin
                if ($urandom_range(0, 3) != 0) begin
                    put_item(OP_CLEAR, 16'($urandom), 16'($urandom),
                             32'($urandom), 32'($urandom));
                end
                repeat ($urandom_range(0, 18)) begin
                    w = pick_dim();
                    h = pick_dim();
                    put_item(OP_APPEND, w, h, 32'($urandom), 32'($urandom));
                end
                repeat ($urandom_range(1, 6)) begin
                    put_item(OP_QUERY, 16'($urandom), 16'($urandom),
                             pick_extent(w), pick_extent(h));
                end
            end
            seq_no++;
            if (seq_no % 15 == 0) begin
                drain_results();
            end
        end

        i_in_valid <= 1'b0;
        @(negedge i_clk);
        while (awaiting != 0) @(negedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

[sim.f]
hdl/ivs_pkg.sv
hdl/ivs_ram.sv
hdl/ivs_xmul.sv
hdl/image_variant_selector.sv
tb/variant_fit_checker.sv
tb/tb_image_variant_selector.sv
